FILE: hdl/mbds_pkg.sv
`timescale 1ns / 1ps
package mbds_pkg;

    localparam int CNT_W     = 4;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_SEP_BYTES       = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SEP_LENGTH      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FIELD_BYTES = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FIELDS      = CFG_IDX_W'(3);

    typedef struct packed {
        logic [31:0] sep_bytes;
        logic [2:0]  sep_length;
        logic [7:0]  max_field_bytes;
        logic [15:0] max_fields;
    } cfg_t;

    typedef struct packed {
        logic             sep_hit;
        logic [15:0]      hit_field;
        logic             hit_kept;
        logic [CNT_W-1:0] byte_count;
        logic [15:0]      field;
        logic             kept;
        logic             last;
        logic [15:0]      total;
    } cmd_t;

endpackage

FILE: hdl/mbds_queue.sv
`timescale 1ns / 1ps
module mbds_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             full,
    output logic             empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign head  = mem[rd_ptr_reg];
    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

endmodule

FILE: hdl/mbds_front.sv
`timescale 1ns / 1ps
module mbds_front
    import mbds_pkg::*;
#(
    parameter int SEP_MAX = 4
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  logic                    in_fire,
    input  logic [7:0]              data_byte,
    input  logic                    byte_present,
    input  logic                    string_last,
    output logic                    push,
    output cmd_t                    cmd,
    output logic [SEP_MAX-1:0][7:0] cmd_bytes
);

    localparam int XW = 2 * SEP_MAX;
    localparam int SW = 8 * SEP_MAX + 32;

    logic [SEP_MAX-1:0][7:0] win_reg, win_next;
    logic [CNT_W-1:0]        fill_reg, fill_next;
    logic [15:0]             field_reg, field_next;
    logic [7:0]              bif_reg, bif_next;

    logic [SW-1:0]           sep_ext;
    logic [SEP_MAX-1:0][7:0] sep;
    logic [CNT_W-1:0]        len;
    logic [XW-1:0][7:0]      winx;
    logic [CNT_W-1:0]        fill_a;
    logic                    hit;
    logic [SEP_MAX:0]        ok;
    logic [CNT_W-1:0]        rel;
    logic [7:0]              room;
    logic [CNT_W-1:0]        emit_cnt;
    logic                    kept_cur;
    logic                    kept_inc;
    logic [15:0]             field_inc;
    logic [15:0]             field_fin;

    always_comb
    begin
        sep_ext = SW'(cfg.sep_bytes);
        for (int k = 0; k < SEP_MAX; k++)
        begin
            sep[k] = sep_ext[8*k +: 8];
        end

        if (cfg.sep_length == 3'd0)
        begin
            len = CNT_W'(1);
        end
        else if (CNT_W'(cfg.sep_length) > CNT_W'(SEP_MAX))
        begin
            len = CNT_W'(SEP_MAX);
        end
        else
        begin
            len = CNT_W'(cfg.sep_length);
        end

        for (int i = 0; i < SEP_MAX; i++)
        begin
            winx[i] = (byte_present && CNT_W'(i) == fill_reg) ? data_byte : win_reg[i];
        end
        for (int i = SEP_MAX; i < XW; i++)
        begin
            winx[i] = 8'd0;
        end
        fill_a = byte_present ? fill_reg + CNT_W'(1) : fill_reg;

        hit = byte_present && (fill_a >= len);
        for (int i = 0; i < SEP_MAX; i++)
        begin
            if (CNT_W'(i) < fill_a && winx[i] != sep[i])
            begin
                hit = 1'b0;
            end
        end

        for (int s = 0; s <= SEP_MAX; s++)
        begin
            ok[s] = (CNT_W'(s) <= fill_a) && ((fill_a - CNT_W'(s)) < len);
            for (int i = 0; i < SEP_MAX; i++)
            begin
                if (CNT_W'(i) < fill_a - CNT_W'(s) && winx[i+s] != sep[i])
                begin
                    ok[s] = 1'b0;
                end
            end
        end

        rel = fill_a;
        for (int s = SEP_MAX; s >= 0; s--)
        begin
            if (ok[s])
            begin
                rel = CNT_W'(s);
            end
        end
        if (hit)
        begin
            rel = '0;
        end
        else if (string_last)
        begin
            rel = fill_a;
        end

        room     = (cfg.max_field_bytes > bif_reg) ? cfg.max_field_bytes - bif_reg : 8'd0;
        kept_cur = (field_reg < cfg.max_fields);
        if (!kept_cur)
        begin
            emit_cnt = '0;
        end
        else if (8'(rel) < room)
        begin
            emit_cnt = rel;
        end
        else
        begin
            emit_cnt = CNT_W'(room);
        end

        field_inc = (field_reg == 16'hFFFF) ? field_reg : field_reg + 16'd1;
        kept_inc  = (field_inc < cfg.max_fields);
        field_fin = hit ? field_inc : field_reg;
    end

    // advance window and field counters
    always_comb
    begin
        win_next   = win_reg;
        fill_next  = fill_reg;
        field_next = field_reg;
        bif_next   = bif_reg;
        if (in_fire && (byte_present || string_last))
        begin
            if (hit || string_last)
            begin
                win_next   = '0;
                fill_next  = '0;
                bif_next   = 8'd0;
                field_next = string_last ? 16'd0 : field_inc;
            end
            else
            begin
                for (int i = 0; i < SEP_MAX; i++)
                begin
                    win_next[i] = 8'd0;
                    for (int j = 0; j < XW; j++)
                    begin
                        if (CNT_W'(j) == CNT_W'(i) + rel)
                        begin
                            win_next[i] = winx[j];
                        end
                    end
                end
                fill_next = fill_a - rel;
                bif_next  = bif_reg + 8'(emit_cnt);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg   <= '0;
            fill_reg  <= '0;
            field_reg <= '0;
            bif_reg   <= '0;
        end
        else
        begin
            win_reg   <= win_next;
            fill_reg  <= fill_next;
            field_reg <= field_next;
            bif_reg   <= bif_next;
        end
    end

    always_comb
    begin
        push           = in_fire && (hit || emit_cnt != '0 || string_last);
        cmd.sep_hit    = hit;
        cmd.hit_field  = field_reg;
        cmd.hit_kept   = kept_cur;
        cmd.byte_count = emit_cnt;
        cmd.field      = field_fin;
        cmd.kept       = hit ? kept_inc : kept_cur;
        cmd.last       = string_last;
        cmd.total      = (field_fin == 16'hFFFF) ? field_fin : field_fin + 16'd1;
        for (int i = 0; i < SEP_MAX; i++)
        begin
            cmd_bytes[i] = winx[i];
        end
    end

endmodule

FILE: hdl/mbds_back.sv
`timescale 1ns / 1ps
module mbds_back
    import mbds_pkg::*;
#(
    parameter int SEP_MAX = 4
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_empty,
    input  cmd_t                    head,
    input  logic [SEP_MAX-1:0][7:0] head_bytes,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [7:0]              out_byte,
    output logic                    out_byte_valid,
    output logic [15:0]             field_number,
    output logic                    field_kept,
    output logic                    field_done,
    output logic                    string_done,
    output logic [15:0]             total_fields,
    output logic                    run_last
);

    logic                    wk_valid_reg, wk_valid_next;
    logic                    hit_pend_reg, hit_pend_next;
    logic                    end_pend_reg, end_pend_next;
    logic [CNT_W-1:0]        left_reg, left_next;
    logic [SEP_MAX-1:0][7:0] sr_reg, sr_next;
    cmd_t                    wk_reg, wk_next;

    logic                    out_valid_reg, out_valid_next;
    logic [7:0]              out_byte_reg, out_byte_next;
    logic                    out_bv_reg, out_bv_next;
    logic [15:0]             field_reg, field_next;
    logic                    kept_reg, kept_next;
    logic                    fdone_reg, fdone_next;
    logic                    sdone_reg, sdone_next;
    logic [15:0]             total_reg, total_next;
    logic                    rlast_reg, rlast_next;

    logic                    adv;
    logic                    emit;
    logic                    fin;
    logic [7:0]              r_byte;
    logic                    r_bv;
    logic [15:0]             r_field;
    logic                    r_kept;
    logic                    r_fdone;
    logic                    r_sdone;

    always_comb
    begin
        adv     = !out_valid_reg || !out_stall;
        emit    = wk_valid_reg && adv;
        r_byte  = 8'd0;
        r_bv    = 1'b0;
        r_field = wk_reg.field;
        r_kept  = wk_reg.kept;
        fin     = 1'b1;
        if (hit_pend_reg)
        begin
            r_field = wk_reg.hit_field;
            r_kept  = wk_reg.hit_kept;
            fin     = (left_reg == '0) && !end_pend_reg;
        end
        else if (left_reg != '0)
        begin
            r_byte = sr_reg[0];
            r_bv   = 1'b1;
            fin    = (left_reg == CNT_W'(1)) && !end_pend_reg;
        end
        r_sdone = fin && wk_reg.last;
        r_fdone = !r_bv || r_sdone;
        pop     = !q_empty && (!wk_valid_reg || (emit && fin));
    end

    always_comb
    begin
        wk_valid_next = wk_valid_reg;
        hit_pend_next = hit_pend_reg;
        end_pend_next = end_pend_reg;
        left_next     = left_reg;
        sr_next       = sr_reg;
        wk_next       = wk_reg;
        if (emit)
        begin
            if (hit_pend_reg)
            begin
                hit_pend_next = 1'b0;
            end
            else if (left_reg != '0)
            begin
                left_next = left_reg - CNT_W'(1);
                for (int i = 0; i < SEP_MAX - 1; i++)
                begin
                    sr_next[i] = sr_reg[i+1];
                end
                sr_next[SEP_MAX-1] = 8'd0;
            end
            else
            begin
                end_pend_next = 1'b0;
            end
            if (fin)
            begin
                wk_valid_next = 1'b0;
            end
        end
        if (pop)
        begin
            wk_valid_next = 1'b1;
            wk_next       = head;
            hit_pend_next = head.sep_hit;
            left_next     = head.byte_count;
            sr_next       = head_bytes;
            end_pend_next = head.last && (head.byte_count == '0);
        end
    end

    always_comb
    begin
        out_valid_next = adv ? wk_valid_reg : out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_bv_next    = out_bv_reg;
        field_next     = field_reg;
        kept_next      = kept_reg;
        fdone_next     = fdone_reg;
        sdone_next     = sdone_reg;
        total_next     = total_reg;
        rlast_next     = rlast_reg;
        if (emit)
        begin
            out_byte_next = r_byte;
            out_bv_next   = r_bv;
            field_next    = r_field;
            kept_next     = r_kept;
            fdone_next    = r_fdone;
            sdone_next    = r_sdone;
            total_next    = r_sdone ? wk_reg.total : 16'd0;
            rlast_next    = fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wk_valid_reg  <= 1'b0;
            hit_pend_reg  <= 1'b0;
            end_pend_reg  <= 1'b0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wk_valid_reg  <= wk_valid_next;
            hit_pend_reg  <= hit_pend_next;
            end_pend_reg  <= end_pend_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sr_reg       <= sr_next;
        wk_reg       <= wk_next;
        out_byte_reg <= out_byte_next;
        out_bv_reg   <= out_bv_next;
        field_reg    <= field_next;
        kept_reg     <= kept_next;
        fdone_reg    <= fdone_next;
        sdone_reg    <= sdone_next;
        total_reg    <= total_next;
        rlast_reg    <= rlast_next;
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign out_byte_valid = out_bv_reg;
    assign field_number   = field_reg;
    assign field_kept     = kept_reg;
    assign field_done     = fdone_reg;
    assign string_done    = sdone_reg;
    assign total_fields   = total_reg;
    assign run_last       = rlast_reg;

endmodule

FILE: hdl/multi_byte_delimiter_splitter_unit.sv
`timescale 1ns / 1ps
// Path: a beat's command is queued, then popped into the back end's work register; its results
// leave through the output register. Throughput: one input beat per cycle unless the queue is
// full; one result beat per cycle unless out_stall is high, so a beat with n results (up to
// SEP_MAX) holds the back end while the 4-entry front-to-back command queue absorbs such bursts.
// Reset (rst_n low, asynchronous): window, field and byte counters and queue clear;
// registers return to separator ',', length 1, 255 bytes per field, 16 fields.
module multi_byte_delimiter_splitter_unit
    import mbds_pkg::*;
#(
    parameter int SEP_MAX = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           data_byte,
    input  logic                 byte_present,
    input  logic                 string_last,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           out_byte,
    output logic                 out_byte_valid,
    output logic [15:0]          field_number,
    output logic                 field_kept,
    output logic                 field_done,
    output logic                 string_done,
    output logic [15:0]          total_fields,
    output logic                 run_last,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int CMD_W   = $bits(cmd_t);
    localparam int QW      = CMD_W + 8 * SEP_MAX;
    localparam int Q_DEPTH = 4;

    cfg_t                    cfg_reg, cfg_next;
    logic                    in_fire;
    logic                    push;
    cmd_t                    cmd;
    logic [SEP_MAX-1:0][7:0] cmd_bytes;
    logic [QW-1:0]           q_head;
    logic                    q_full;
    logic                    q_empty;
    logic                    pop;
    cmd_t                    head_cmd;
    logic [SEP_MAX-1:0][7:0] head_bytes;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SEP_BYTES:       cfg_next.sep_bytes       = cfg_data;
                CFG_SEP_LENGTH:      cfg_next.sep_length      = cfg_data[2:0];
                CFG_MAX_FIELD_BYTES: cfg_next.max_field_bytes = cfg_data[7:0];
                CFG_MAX_FIELDS:      cfg_next.max_fields      = cfg_data[15:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sep_bytes       <= 32'd44;
            cfg_reg.sep_length      <= 3'd1;
            cfg_reg.max_field_bytes <= 8'd255;
            cfg_reg.max_fields      <= 16'd16;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign in_fire   = in_valid && !in_stall;

    mbds_front #(
        .SEP_MAX (SEP_MAX)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_fire      (in_fire),
        .data_byte    (data_byte),
        .byte_present (byte_present),
        .string_last  (string_last),
        .push         (push),
        .cmd          (cmd),
        .cmd_bytes    (cmd_bytes)
    );

    mbds_queue #(
        .WIDTH (QW),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({cmd, cmd_bytes}),
        .pop       (pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign head_cmd   = cmd_t'(q_head[QW-1 -: CMD_W]);
    assign head_bytes = q_head[8*SEP_MAX-1:0];

    mbds_back #(
        .SEP_MAX (SEP_MAX)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .head           (head_cmd),
        .head_bytes     (head_bytes),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .out_byte_valid (out_byte_valid),
        .field_number   (field_number),
        .field_kept     (field_kept),
        .field_done     (field_done),
        .string_done    (string_done),
        .total_fields   (total_fields),
        .run_last       (run_last)
    );

endmodule

FILE: tb/sv/tb_multi_byte_delimiter_splitter_unit.sv
`timescale 1ns / 1ps
module tb_multi_byte_delimiter_splitter_unit;
    import mbds_pkg::*;

    localparam int SEP_MAX = 4;
    localparam int LIMIT = 600000;
    localparam int DRAIN = 16;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        out_byte_valid;
        logic [15:0] field_number;
        logic        field_kept;
        logic        field_done;
        logic        string_done;
        logic [15:0] total_fields;
        logic        run_last;
    } split_beat_t;

    class split_predictor;
        logic [31:0] sep_word;
        logic [2:0]  sep_count;
        logic [7:0]  byte_limit;
        logic [15:0] field_limit;
        logic [7:0]  held [SEP_MAX];
        int          held_fill;
        logic [15:0] field_idx;
        logic [7:0]  kept_bytes;
        int          close_slot;
        split_beat_t burst [$];
        split_beat_t pending_beats [$];
        int          mismatches;

        function new();
            sep_word = 32'd44;
            sep_count = 3'd1;
            byte_limit = 8'd255;
            field_limit = 16'd16;
            mismatches = 0;
            clear_string();
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
            case (idx)
                CFG_SEP_BYTES:       sep_word = value;
                CFG_SEP_LENGTH:      sep_count = value[2:0];
                CFG_MAX_FIELD_BYTES: byte_limit = value[7:0];
                CFG_MAX_FIELDS:      field_limit = value[15:0];
                default:             ;
            endcase
        endfunction

        function int sep_len();
            if (sep_count == 3'd0)
                return 1;
            if (sep_count > SEP_MAX)
                return SEP_MAX;
            return sep_count;
        endfunction

        function logic [7:0] sep_byte(int k);
            if (k >= 4)
                return 8'h00;
            return sep_word[8*k +: 8];
        endfunction

        function void clear_window();
            foreach (held[i])
                held[i] = 8'h00;
            held_fill = 0;
        endfunction

        function void clear_string();
            clear_window();
            field_idx = 16'd0;
            kept_bytes = 8'd0;
        endfunction

        function bit window_is_prefix();
            for (int i = 0; i < held_fill; i++)
                if (held[i] != sep_byte(i))
                    return 1'b0;
            return 1'b1;
        endfunction

        function void add_beat(logic [7:0] b, logic valid, logic done);
            split_beat_t r;
            r = '0;
            r.out_byte = valid ? b : 8'h00;
            r.out_byte_valid = valid;
            r.field_number = field_idx;
            r.field_kept = field_idx < field_limit;
            r.field_done = done;
            burst.push_back(r);
        endfunction

        function void release_oldest();
            logic [7:0] b;
            b = held[0];
            for (int i = 0; i < held_fill - 1; i++)
                held[i] = held[i+1];
            held_fill--;
            held[held_fill] = 8'h00;
            if (field_idx < field_limit && kept_bytes < byte_limit)
            begin
                add_beat(b, 1'b1, 1'b0);
                kept_bytes++;
                close_slot = burst.size() - 1;
            end
        endfunction

        function void take_char(logic [7:0] data, logic present, logic last);
            int          l;
            logic [16:0] total;
            burst.delete();
            close_slot = -1;
            l = sep_len();
            if (present)
            begin
                if (held_fill < SEP_MAX)
                begin
                    held[held_fill] = data;
                    held_fill++;
                end
                if (held_fill >= l && window_is_prefix())
                begin
                    add_beat(8'h00, 1'b0, 1'b1);
                    if (field_idx != 16'hFFFF)
                        field_idx++;
                    kept_bytes = 8'd0;
                    clear_window();
                    close_slot = -1;
                end
                else
                    while (held_fill > 0 && (held_fill >= l || !window_is_prefix()))
                        release_oldest();
            end
            if (last)
            begin
                while (held_fill > 0)
                    release_oldest();
                if (close_slot < 0)
                begin
                    add_beat(8'h00, 1'b0, 1'b1);
                    close_slot = burst.size() - 1;
                end
                total = {1'b0, field_idx} + 17'd1;
                burst[close_slot].field_done = 1'b1;
                burst[close_slot].string_done = 1'b1;
                burst[close_slot].total_fields = (total > 17'hFFFF) ? 16'hFFFF : total[15:0];
                clear_string();
            end
            if (burst.size() > 0)
                burst[burst.size()-1].run_last = 1'b1;
            foreach (burst[i])
                pending_beats.push_back(burst[i]);
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void match_beat(split_beat_t got);
            split_beat_t want;
            if (pending_beats.size() == 0)
            begin
                $error("result beat with nothing pending: field_number %0d", got.field_number);
                mismatches++;
                return;
            end
            want = pending_beats.pop_front();
            check_field("out_byte", want.out_byte, got.out_byte);
            check_field("out_byte_valid", want.out_byte_valid, got.out_byte_valid);
            check_field("field_number", want.field_number, got.field_number);
            check_field("field_kept", want.field_kept, got.field_kept);
            check_field("field_done", want.field_done, got.field_done);
            check_field("string_done", want.string_done, got.string_done);
            check_field("total_fields", want.total_fields, got.total_fields);
            check_field("run_last", want.run_last, got.run_last);
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [7:0]           data_byte = 8'h00;
    logic                 byte_present = 1'b0;
    logic                 string_last = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [7:0]           out_byte;
    logic                 out_byte_valid;
    logic [15:0]          field_number;
    logic                 field_kept;
    logic                 field_done;
    logic                 string_done;
    logic [15:0]          total_fields;
    logic                 run_last;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;

    split_predictor tracker;
    int             tx_mode = 0;
    int             rx_mode = 0;
    bit             hold_long = 1'b0;
    int             chars_sent = 0;

    multi_byte_delimiter_splitter_unit #(
        .SEP_MAX(SEP_MAX)
    ) u_top (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int draw_gap(int mode);
        case (mode)
            0:       return 0;
            1:       return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
            default: return $urandom_range(0, 11);
        endcase
    endfunction

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            tracker.match_beat(split_beat_t'{out_byte, out_byte_valid, field_number, field_kept,
                                             field_done, string_done, total_fields, run_last});

    initial
    begin
        int stall_cycles;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_long)
            begin
                hold_long = 1'b0;
                stall_cycles = 300;
            end
            else
                stall_cycles = draw_gap(rx_mode);
            if (stall_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    initial
    begin
        repeat (LIMIT) @(posedge clk);
        $display("CHECK FAILED");
        $finish;
    end

    task automatic program_regs(input logic [31:0] sep, input logic [2:0] len,
                                input logic [7:0] fb, input logic [15:0] nf);
        logic [CFG_IDX_W-1:0] idxs [4];
        logic [31:0]          vals [4];
        idxs = '{CFG_SEP_BYTES, CFG_SEP_LENGTH, CFG_MAX_FIELD_BYTES, CFG_MAX_FIELDS};
        vals = '{sep, {29'd0, len}, {24'd0, fb}, {16'd0, nf}};
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idxs[i];
            cfg_data <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            tracker.set_reg(idxs[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_item(input logic [7:0] data, input logic present, input logic last);
        int gap;
        gap = draw_gap(tx_mode);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= data;
        byte_present <= present;
        string_last <= last;
        do
            @(posedge clk);
        while (in_stall);
        tracker.take_char(data, present, last);
        if (present || last)
            chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b1, i == s.len() - 1);
    endtask

    task automatic send_string();
        int span;
        int pushed;
        int sl;
        int cut;
        span = $urandom_range(0, 14);
        pushed = 0;
        sl = tracker.sep_len();
        while (pushed < span)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    for (int k = 0; k < sl; k++)
                        send_item(tracker.sep_byte(k), 1'b1, 1'b0);
                    pushed += sl;
                end
                3, 4:
                begin
                    cut = $urandom_range(1, sl);
                    for (int k = 0; k < cut; k++)
                        send_item(tracker.sep_byte(k), 1'b1, 1'b0);
                    send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
                    pushed += cut + 1;
                end
                5, 6:
                begin
                    send_item(tracker.sep_byte($urandom_range(0, sl - 1)), 1'b1, 1'b0);
                    pushed++;
                end
                7, 8:
                begin
                    send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
                    pushed++;
                end
                default:
                begin
                    send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                    pushed++;
                end
            endcase
        end
        send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.pending_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    initial
    begin
        int          target;
        logic [7:0]  base;
        logic [31:0] sep;
        logic [2:0]  len;
        logic [7:0]  fb;
        logic [15:0] nf;
        tracker = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_mode = 2;
        rx_mode = 2;
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hA5, 1'b0, 1'b1);
        send_text("a,b");
        send_text(",,");
        send_item(8'h00, 1'b1, 1'b0);
        send_item(",", 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);
        settle();

        tx_mode = 1;
        rx_mode = 1;
        program_regs(32'h0062_6161, 3'd3, 8'd2, 16'd2);
        send_text("aaabxyzaabq");
        settle();

        program_regs(32'h0000_00FF, 3'd0, 8'd0, 16'd0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);
        settle();

        program_regs(32'hFFFF_FFFF, 3'd7, 8'd1, 16'hFFFF);
        repeat (5) send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h7F, 1'b1, 1'b1);
        settle();

        for (int p = 0; p < 4; p++)
        begin
            base = 8'($urandom_range(0, 255));
            for (int k = 0; k < 4; k++)
                case ($urandom_range(0, 2))
                    0:       sep[8*k +: 8] = base;
                    1:       sep[8*k +: 8] = base ^ 8'h01;
                    default: sep[8*k +: 8] = 8'($urandom_range(0, 255));
                endcase
            len = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
            case ($urandom_range(0, 3))
                0:       fb = 8'($urandom_range(1, 6));
                1:       fb = 8'd255;
                2:       fb = 8'($urandom_range(0, 255));
                default: fb = 8'd0;
            endcase
            case ($urandom_range(0, 4))
                0:       nf = 16'($urandom_range(1, 4));
                1:       nf = 16'hFFFF;
                2:       nf = 16'($urandom_range(0, 65535));
                3:       nf = 16'($urandom_range(2, 8));
                default: nf = 16'd0;
            endcase
            program_regs(sep, len, fb, nf);
            tx_mode = $urandom_range(0, 2);
            rx_mode = $urandom_range(0, 2);
            if (p == 2)
            begin
                tx_mode = 0;
                hold_long = 1'b1;
            end
            target = chars_sent + 45;
            while (chars_sent < target)
                send_string();
            settle();
        end

        tx_mode = 0;
        rx_mode = 0;
        program_regs(32'h0000_003B, 3'd1, 8'd255, 16'hFFFF);
        repeat (3) send_item(8'h61, 1'b1, 1'b0);
        repeat (3) send_item(8'h3B, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b1);
        settle();

        if (tracker.mismatches == 0 && tracker.pending_beats.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: multi_byte_delimiter_splitter_unit.f
hdl/mbds_pkg.sv
hdl/mbds_queue.sv
hdl/mbds_front.sv
hdl/mbds_back.sv
hdl/multi_byte_delimiter_splitter_unit.sv
tb/sv/tb_multi_byte_delimiter_splitter_unit.sv
